[rtl/core/hsc_pkg.sv]
package hsc_pkg;

    localparam int CharWidth   = 8;
    localparam int CfgWidth    = 6;
    localparam int LenWidth    = 7;
    localparam logic [LenWidth-1:0] LenSat = 7'd64;

    localparam logic [CfgWidth-1:0] MaxLabelReset = 6'd63;
    localparam logic [CfgWidth-1:0] MinTopReset   = 6'd2;

    localparam logic [CharWidth-1:0] CharDot    = 8'h2E;
    localparam logic [CharWidth-1:0] CharHyphen = 8'h2D;

    typedef enum logic [0:0] {
        CFG_MAX_LABEL = 1'b0,
        CFG_MIN_TOP   = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BADCHAR  = 3'd1,
        ERR_EMPTY    = 3'd2,
        ERR_TOOLONG  = 3'd3,
        ERR_HYPHEN   = 3'd4,
        ERR_NODOT    = 3'd5,
        ERR_TLDSHORT = 3'd6,
        ERR_TLDALPHA = 3'd7
    } err_t;

endpackage

[rtl/core/hostname_syntax_checker.sv]
// Channel   Direction  Fields (tdata from bit 0)                  Marker
// s_*       in         char_code[7:0]                              tlast = is_end
// m_*       out        name_valid[0], error_code[3:1], zero[7:4]   none
// cfg_*     in         cfg_data = register value, cfg_index 0..1   cfg_we
//
// One item is accepted per cycle; a character item updates the label state in
// the cycle it is accepted, and an end item places its result in the output
// register in that cycle too. Input is refused only while a result waits in the
// output register and m_tready is low. Reset clears the label state and the
// output valid and loads the register defaults (63 and 2).
module hostname_syntax_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hsc_pkg::CharWidth-1:0]    s_tdata,   // char_code[7:0]
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // name_valid, error_code[2:0], zeros
    input  logic                             cfg_we,
    input  logic [0:0]                       cfg_index,
    input  logic [hsc_pkg::CfgWidth-1:0]     cfg_data
);

    logic [hsc_pkg::CfgWidth-1:0] max_label_reg;
    logic [hsc_pkg::CfgWidth-1:0] min_top_reg;

    logic [hsc_pkg::LenWidth-1:0] label_length_reg, label_length_next;
    logic                         last_hyphen_reg, last_hyphen_next;
    logic                         dot_seen_reg, dot_seen_next;
    logic                         all_letters_reg, all_letters_next;
    hsc_pkg::err_t                first_error_reg, first_error_next;

    logic                         out_valid_reg, out_valid_next;
    hsc_pkg::err_t                out_error_reg, out_error_next;

    logic                         accept;
    hsc_pkg::err_t                label_err;
    hsc_pkg::err_t                end_err;
    logic                         is_letter;
    logic                         is_digit;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_error_reg, (out_error_reg == hsc_pkg::ERR_NONE)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_label_reg <= hsc_pkg::MaxLabelReset;
            min_top_reg   <= hsc_pkg::MinTopReset;
        end
        else if (cfg_we)
        begin
            case (hsc_pkg::cfg_index_t'(cfg_index))
                hsc_pkg::CFG_MAX_LABEL: max_label_reg <= cfg_data;
                hsc_pkg::CFG_MIN_TOP:   min_top_reg   <= cfg_data;
                default:                max_label_reg <= max_label_reg;
            endcase
        end
    end

    always_comb
    begin
        is_letter = (s_tdata inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        is_digit  = (s_tdata inside {[8'h30:8'h39]});

        if (label_length_reg == '0)
            label_err = hsc_pkg::ERR_EMPTY;
        else if (label_length_reg > {1'b0, max_label_reg})
            label_err = hsc_pkg::ERR_TOOLONG;
        else if (last_hyphen_reg)
            label_err = hsc_pkg::ERR_HYPHEN;
        else
            label_err = hsc_pkg::ERR_NONE;

        if (first_error_reg != hsc_pkg::ERR_NONE)
            end_err = first_error_reg;
        else if (label_err != hsc_pkg::ERR_NONE)
            end_err = label_err;
        else if (!dot_seen_reg)
            end_err = hsc_pkg::ERR_NODOT;
        else if (label_length_reg < {1'b0, min_top_reg})
            end_err = hsc_pkg::ERR_TLDSHORT;
        else if (!all_letters_reg)
            end_err = hsc_pkg::ERR_TLDALPHA;
        else
            end_err = hsc_pkg::ERR_NONE;
    end

    always_comb
    begin
        label_length_next = label_length_reg;
        last_hyphen_next  = last_hyphen_reg;
        dot_seen_next     = dot_seen_reg;
        all_letters_next  = all_letters_reg;
        first_error_next  = first_error_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_error_next    = out_error_reg;

        if (accept)
        begin
            if (s_tlast)
            begin
                out_valid_next    = 1'b1;
                out_error_next    = end_err;
                label_length_next = '0;
                last_hyphen_next  = 1'b0;
                dot_seen_next     = 1'b0;
                all_letters_next  = 1'b1;
                first_error_next  = hsc_pkg::ERR_NONE;
            end
            else if (first_error_reg == hsc_pkg::ERR_NONE)
            begin
                if (s_tdata == hsc_pkg::CharDot)
                begin
                    first_error_next  = label_err;
                    dot_seen_next     = 1'b1;
                    label_length_next = '0;
                    last_hyphen_next  = 1'b0;
                    all_letters_next  = 1'b1;
                end
                else if (is_letter || is_digit || s_tdata == hsc_pkg::CharHyphen)
                begin
                    if (label_length_reg < hsc_pkg::LenSat)
                        label_length_next = label_length_reg + 1'b1;
                    last_hyphen_next = (s_tdata == hsc_pkg::CharHyphen);
                    if (!is_letter)
                        all_letters_next = 1'b0;
                end
                else
                begin
                    first_error_next = hsc_pkg::ERR_BADCHAR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_length_reg <= '0;
            last_hyphen_reg  <= 1'b0;
            dot_seen_reg     <= 1'b0;
            all_letters_reg  <= 1'b1;
            first_error_reg  <= hsc_pkg::ERR_NONE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            label_length_reg <= label_length_next;
            last_hyphen_reg  <= last_hyphen_next;
            dot_seen_reg     <= dot_seen_next;
            all_letters_reg  <= all_letters_next;
            first_error_reg  <= first_error_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_error_reg <= out_error_next;
    end

`ifndef ASSERT_OFF
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> m_tvalid)
        else $error("end item did not produce a result");

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (label_length_reg == '0 && !dot_seen_reg &&
            first_error_reg == hsc_pkg::ERR_NONE && all_letters_reg))
        else $error("name state not cleared after end item");

    a_length_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        label_length_reg <= hsc_pkg::LenSat)
        else $error("label length above saturation");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (first_error_reg != hsc_pkg::ERR_NONE && !(accept && s_tlast))
            |=> $stable(first_error_reg))
        else $error("first error changed before end item");
`endif

endmodule
